// ----- hw/rtl/bsc_pkg.sv -----
package bsc_pkg;

  localparam int NUM_PROCS   = 5;
  localparam int COUNT_BITS  = 8;
  localparam int NUM_RES     = 3;
  localparam int AVAIL_BITS  = 11;
  localparam int ADDR_BITS   = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int SUM_BITS    = ((AVAIL_BITS > COUNT_BITS) ? AVAIL_BITS : COUNT_BITS) + 1;
  localparam logic [AVAIL_BITS-1:0] AVAIL_MAX = {AVAIL_BITS{1'b1}};

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [AVAIL_BITS-1:0] avail_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  typedef enum logic [1:0] {
    OP_LOAD_AVAIL = 2'd0,
    OP_LOAD_ROW   = 2'd1,
    OP_RUN        = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] proc_index;
    logic [7:0] avail_0;
    logic [7:0] avail_1;
    logic [7:0] avail_2;
    logic [7:0] alloc_0;
    logic [7:0] alloc_1;
    logic [7:0] alloc_2;
    logic [7:0] max_0;
    logic [7:0] max_1;
    logic [7:0] max_2;
  } cmd_t;

  typedef struct packed {
    logic [2:0] picked_proc;
    logic       is_verdict;
    logic       system_safe;
  } result_t;

  typedef struct packed {
    count_t [NUM_RES-1:0] alloc;
    count_t [NUM_RES-1:0] claim;
  } row_t;

  typedef struct packed {
    logic load_avail;
    logic grant;
  } dp_ctrl_t;

  function automatic count_t count_of(logic [7:0] v);
    return count_t'(v);
  endfunction

endpackage

// ----- hw/rtl/banker_safety_check_top.sv -----
// Load transactions (available vector, process row) leave busy low.
// A run checks one row at a time in two steps: RAM read, then evaluate.
// Each result is strobed in the cycle after its row evaluation; the receiver cannot stall.
// Synchronous reset clears the available vector, finished marks and control;
// process rows are undefined until loaded.
module banker_safety_check_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  bsc_pkg::cmd_t    cmd,
  output logic             result_valid,
  output bsc_pkg::result_t result
);

  logic              row_we;
  bsc_pkg::addr_t    row_waddr;
  bsc_pkg::row_t     row_wdata;
  bsc_pkg::row_t     row_rdata;
  logic [$bits(bsc_pkg::row_t)-1:0] row_rbits;
  bsc_pkg::addr_t    rd_addr;
  bsc_pkg::dp_ctrl_t ctrl;
  logic              fits;

  assign row_we = start && !busy && (cmd.operation == bsc_pkg::OP_LOAD_ROW) &&
                  (32'(cmd.proc_index) < 32'(bsc_pkg::NUM_PROCS));
  assign row_waddr = bsc_pkg::ADDR_BITS'(cmd.proc_index);

  assign row_wdata.alloc[0] = bsc_pkg::count_of(cmd.alloc_0);
  assign row_wdata.alloc[1] = bsc_pkg::count_of(cmd.alloc_1);
  assign row_wdata.alloc[2] = bsc_pkg::count_of(cmd.alloc_2);
  assign row_wdata.claim[0] = bsc_pkg::count_of(cmd.max_0);
  assign row_wdata.claim[1] = bsc_pkg::count_of(cmd.max_1);
  assign row_wdata.claim[2] = bsc_pkg::count_of(cmd.max_2);

  assign row_rdata = bsc_pkg::row_t'(row_rbits);

  bsc_row_ram #(
    .WIDTH($bits(bsc_pkg::row_t)),
    .DEPTH(bsc_pkg::NUM_PROCS)
  ) u_row_ram (
    .clk  (clk),
    .we   (row_we),
    .waddr(row_waddr),
    .wdata(row_wdata),
    .raddr(rd_addr),
    .rdata(row_rbits)
  );

  bsc_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .ctrl(ctrl),
    .cmd (cmd),
    .row (row_rdata),
    .fits(fits)
  );

  bsc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd_op      (cmd.operation),
    .fits        (fits),
    .busy        (busy),
    .rd_addr     (rd_addr),
    .ctrl        (ctrl),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

// ----- hw/rtl/bsc_row_ram.sv -----
module bsc_row_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bsc_datapath.sv -----
module bsc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  bsc_pkg::dp_ctrl_t ctrl,
  input  bsc_pkg::cmd_t     cmd,
  input  bsc_pkg::row_t     row,
  output logic              fits
);

  bsc_pkg::avail_t [bsc_pkg::NUM_RES-1:0] avail;
  bsc_pkg::avail_t [bsc_pkg::NUM_RES-1:0] avail_next;
  bsc_pkg::avail_t [bsc_pkg::NUM_RES-1:0] avail_load;
  logic [bsc_pkg::NUM_RES-1:0][bsc_pkg::SUM_BITS-1:0] sum;
  logic [bsc_pkg::NUM_RES-1:0] res_ok;

  assign avail_load[0] = bsc_pkg::AVAIL_BITS'(bsc_pkg::count_of(cmd.avail_0));
  assign avail_load[1] = bsc_pkg::AVAIL_BITS'(bsc_pkg::count_of(cmd.avail_1));
  assign avail_load[2] = bsc_pkg::AVAIL_BITS'(bsc_pkg::count_of(cmd.avail_2));

  always_comb begin
    for (int r = 0; r < bsc_pkg::NUM_RES; r++) begin
      sum[r] = bsc_pkg::SUM_BITS'(avail[r]) + bsc_pkg::SUM_BITS'(row.alloc[r]);
      res_ok[r] = sum[r] >= bsc_pkg::SUM_BITS'(row.claim[r]);
    end
  end

  assign fits = &res_ok;

  always_comb begin
    avail_next = avail;
    if (ctrl.load_avail) begin
      avail_next = avail_load;
    end else if (ctrl.grant) begin
      for (int r = 0; r < bsc_pkg::NUM_RES; r++) begin
        avail_next[r] = (sum[r] > bsc_pkg::SUM_BITS'(bsc_pkg::AVAIL_MAX)) ?
                        bsc_pkg::AVAIL_MAX : bsc_pkg::AVAIL_BITS'(sum[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avail <= '0;
    end else begin
      avail <= avail_next;
    end
  end

endmodule

// ----- hw/rtl/bsc_ctrl.sv -----
module bsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        cmd_op,
  input  logic              fits,
  output logic              busy,
  output bsc_pkg::addr_t    rd_addr,
  output bsc_pkg::dp_ctrl_t ctrl,
  output logic              result_valid,
  output bsc_pkg::result_t  result
);

  localparam bsc_pkg::addr_t LAST_PROC = bsc_pkg::ADDR_BITS'(bsc_pkg::NUM_PROCS - 1);

  bsc_pkg::state_t state, state_next;
  bsc_pkg::addr_t  scan, scan_next;
  logic [bsc_pkg::NUM_PROCS-1:0] finished, finished_next;
  logic             result_valid_next;
  bsc_pkg::result_t result_next;
  logic             run_req;
  logic             fit;
  logic             at_last;

  assign run_req = start && (cmd_op == bsc_pkg::OP_RUN);
  assign fit     = !finished[scan] && fits;
  assign at_last = (scan == LAST_PROC);

  always_comb begin
    state_next = state;
    unique case (state)
      bsc_pkg::S_IDLE: begin
        if (run_req) begin
          state_next = bsc_pkg::S_READ;
        end
      end
      bsc_pkg::S_READ: begin
        state_next = bsc_pkg::S_EVAL;
      end
      bsc_pkg::S_EVAL: begin
        if (fit) begin
          state_next = bsc_pkg::S_READ;
        end else if (at_last) begin
          state_next = bsc_pkg::S_IDLE;
        end else begin
          state_next = bsc_pkg::S_READ;
        end
      end
      default: begin
        state_next = bsc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy            = (state != bsc_pkg::S_IDLE);
    rd_addr         = scan;
    ctrl.load_avail = (state == bsc_pkg::S_IDLE) && start &&
                      (cmd_op == bsc_pkg::OP_LOAD_AVAIL);
    ctrl.grant      = (state == bsc_pkg::S_EVAL) && fit;
  end

  always_comb begin
    scan_next         = scan;
    finished_next     = finished;
    result_valid_next = 1'b0;
    result_next       = result;
    unique case (state)
      bsc_pkg::S_IDLE: begin
        if (run_req) begin
          scan_next     = '0;
          finished_next = '0;
        end
      end
      bsc_pkg::S_READ: begin
      end
      bsc_pkg::S_EVAL: begin
        if (fit) begin
          finished_next[scan]     = 1'b1;
          scan_next               = '0;
          result_valid_next       = 1'b1;
          result_next.picked_proc = 3'(scan);
          result_next.is_verdict  = 1'b0;
          result_next.system_safe = 1'b0;
        end else if (at_last) begin
          result_valid_next       = 1'b1;
          result_next.picked_proc = '0;
          result_next.is_verdict  = 1'b1;
          result_next.system_safe = &finished;
        end else begin
          scan_next = scan + bsc_pkg::addr_t'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bsc_pkg::S_IDLE;
      scan         <= '0;
      finished     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      scan         <= scan_next;
      finished     <= finished_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_result_after_eval: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == bsc_pkg::S_EVAL))
    else $error("result without an evaluation");

  a_verdict_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_verdict |-> state == bsc_pkg::S_IDLE)
    else $error("verdict while run still active");

  a_grant_rescans: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_verdict |-> state == bsc_pkg::S_READ && scan == '0)
    else $error("grant did not restart the scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state != bsc_pkg::S_IDLE |-> scan <= LAST_PROC)
    else $error("scan beyond last process");

endmodule
